// File: hdl/gcol_pkg.sv
// shared types and constants for the greedy constraint coloring block
package gcol_pkg;

    // fixed field widths
    localparam int IDX_W     = 16;
    localparam int MCOUNT_W  = 3;
    localparam int COLOR_W   = 5;
    localparam int USED_W    = 6;
    localparam int LIMIT_W   = 11;

    // particle fields carried by one request, and how many of them take part
    localparam int FIELDS      = 4;
    localparam int MEMBERS     = 4;
    localparam int FIELDS_USED = (MEMBERS < FIELDS) ? MEMBERS : FIELDS;
    localparam int SLOT_W      = (FIELDS_USED > 1) ? $clog2(FIELDS_USED) : 1;

    // configuration port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_PARTICLE_LIMIT = REG_IDX_W'(0);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = LIMIT_W'(1024);

    // request commands
    localparam logic CMD_COLOR = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef logic [IDX_W-1:0] particle_t;

endpackage

// File: hdl/gcol_apb.sv
// configuration register block behind the apb-style port
module gcol_apb (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcol_pkg::APB_AW-1:0]   paddr,
    input  logic [gcol_pkg::APB_DW-1:0]   pwdata,
    output logic [gcol_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [gcol_pkg::LIMIT_W-1:0]  particle_limit
);
    import gcol_pkg::*;

    logic [LIMIT_W-1:0]   limit_reg;
    logic [LIMIT_W-1:0]   limit_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        limit_next = limit_reg;
        if (wr_en && (reg_idx == REG_PARTICLE_LIMIT)) begin
            limit_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PARTICLE_LIMIT: prdata = APB_DW'(limit_reg);
            default:            prdata = '0;
        endcase
    end

    assign particle_limit = limit_reg;

endmodule

// File: hdl/gcol_mask_mem.sv
// per-particle used-color mask store, one write and one registered read port
module gcol_mask_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/gcol_seq.sv
// request sequencer: mask reads, lowest free color pick, mask write-back, clear sweep
module gcol_seq #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_COLORS    = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [gcol_pkg::LIMIT_W-1:0]      particle_limit,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  gcol_pkg::particle_t               s_particle [gcol_pkg::FIELDS],
    input  logic [gcol_pkg::MCOUNT_W-1:0]     s_member_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [gcol_pkg::COLOR_W-1:0]      m_assigned_color,
    output logic [gcol_pkg::USED_W-1:0]       m_colors_used,
    output logic                              m_overflow,
    output logic                              mem_we,
    output logic [$clog2(MAX_PARTICLES)-1:0]  mem_waddr,
    output logic [MAX_COLORS-1:0]             mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(MAX_PARTICLES)-1:0]  mem_raddr,
    input  logic [MAX_COLORS-1:0]             mem_rdata
);
    import gcol_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_COLORS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_GATHER,
        ST_PICK,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [AW-1:0]         sweep_reg, sweep_next;
    logic [AW-1:0]         idx_reg [FIELDS_USED];
    logic [AW-1:0]         idx_next [FIELDS_USED];
    logic [FIELDS_USED-1:0] vld_reg, vld_next;
    logic [MAX_COLORS-1:0] mask_reg [FIELDS_USED];
    logic [MAX_COLORS-1:0] mask_next [FIELDS_USED];
    logic                  rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [CW-1:0]         color_reg, color_next;
    logic [USED_W-1:0]     count_reg, count_next;
    logic                  clr_pend_reg, clr_pend_next;
    logic [COLOR_W-1:0]    res_color_reg, res_color_next;
    logic [USED_W-1:0]     res_used_reg, res_used_next;
    logic                  res_ovf_reg, res_ovf_next;
    logic                  m_valid_reg, m_valid_next;
    logic [COLOR_W-1:0]    m_color_reg, m_color_next;
    logic [USED_W-1:0]     m_used_reg, m_used_next;
    logic                  m_ovf_reg, m_ovf_next;

    logic [MCOUNT_W-1:0]   n_sat;
    logic [MAX_COLORS-1:0] used;
    logic                  found;
    logic [CW-1:0]         pick;
    logic [USED_W:0]       cand;
    logic [USED_W:0]       pick_ext;
    logic [USED_W-1:0]     new_count;
    logic                  last_slot;

    assign last_slot = (slot_reg == SLOT_W'(FIELDS_USED - 1));

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        sweep_next     = sweep_reg;
        idx_next       = idx_reg;
        vld_next       = vld_reg;
        mask_next      = mask_reg;
        rd_pend_next   = 1'b0;
        rd_slot_next   = slot_reg;
        color_next     = color_reg;
        count_next     = count_reg;
        clr_pend_next  = clr_pend_reg;
        res_color_next = res_color_reg;
        res_used_next  = res_used_reg;
        res_ovf_next   = res_ovf_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_color_next   = m_color_reg;
        m_used_next    = m_used_reg;
        m_ovf_next     = m_ovf_reg;

        mem_we    = 1'b0;
        mem_waddr = idx_reg[slot_reg];
        mem_wdata = mask_reg[slot_reg] | (MAX_COLORS'(1) << color_reg);
        mem_re    = 1'b0;
        mem_raddr = idx_reg[slot_reg];

        n_sat = (s_member_count > MCOUNT_W'(FIELDS_USED)) ?
                MCOUNT_W'(FIELDS_USED) : s_member_count;

        used = '0;
        for (int k = 0; k < FIELDS_USED; k++) begin
            used = used | mask_reg[k];
        end
        found = 1'b0;
        pick  = '0;
        for (int i = MAX_COLORS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                found = 1'b1;
                pick  = CW'(i);
            end
        end
        pick_ext  = (USED_W + 1)'(pick);
        cand      = pick_ext + (USED_W + 1)'(1);
        new_count = (cand > {1'b0, count_reg}) ? cand[USED_W-1:0] : count_reg;

        // read data lands in the cycle after its address
        if (rd_pend_reg) begin
            mask_next[rd_slot_reg] = vld_reg[rd_slot_reg] ? mem_rdata : '0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(MAX_PARTICLES - 1)) begin
                    sweep_next = '0;
                    if (clr_pend_reg) begin
                        clr_pend_next  = 1'b0;
                        res_color_next = '0;
                        res_used_next  = '0;
                        res_ovf_next   = 1'b0;
                        state_next     = ST_DONE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_CLEAR) begin
                        count_next    = '0;
                        sweep_next    = '0;
                        clr_pend_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end else begin
                        for (int k = 0; k < FIELDS_USED; k++) begin
                            idx_next[k] = s_particle[k][AW-1:0];
                            vld_next[k] = (MCOUNT_W'(k) < n_sat)
                                && ({1'b0, s_particle[k]} < (IDX_W + 1)'(particle_limit))
                                && ({1'b0, s_particle[k]} < (IDX_W + 1)'(MAX_PARTICLES));
                        end
                        slot_next  = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                mem_re       = 1'b1;
                rd_pend_next = 1'b1;
                rd_slot_next = slot_reg;
                slot_next    = slot_reg + SLOT_W'(1);
                if (last_slot) begin
                    slot_next  = '0;
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                if (!found) begin
                    res_color_next = '0;
                    res_used_next  = count_reg;
                    res_ovf_next   = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    color_next     = pick;
                    count_next     = new_count;
                    res_color_next = pick_ext[COLOR_W-1:0];
                    res_used_next  = new_count;
                    res_ovf_next   = 1'b0;
                    slot_next      = '0;
                    state_next     = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // repeated members write the same value more than once, which is harmless
                mem_we    = vld_reg[slot_reg];
                slot_next = slot_reg + SLOT_W'(1);
                if (last_slot) begin
                    slot_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_color_next = res_color_reg;
                    m_used_next  = res_used_reg;
                    m_ovf_next   = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            slot_reg     <= '0;
            sweep_reg    <= '0;
            rd_pend_reg  <= 1'b0;
            count_reg    <= '0;
            clr_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            sweep_reg    <= sweep_next;
            rd_pend_reg  <= rd_pend_next;
            count_reg    <= count_next;
            clr_pend_reg <= clr_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        idx_reg       <= idx_next;
        vld_reg       <= vld_next;
        mask_reg      <= mask_next;
        rd_slot_reg   <= rd_slot_next;
        color_reg     <= color_next;
        res_color_reg <= res_color_next;
        res_used_reg  <= res_used_next;
        res_ovf_reg   <= res_ovf_next;
        m_color_reg   <= m_color_next;
        m_used_reg    <= m_used_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_assigned_color = m_color_reg;
    assign m_colors_used    = m_used_reg;
    assign m_overflow       = m_ovf_reg;

endmodule

// File: hdl/greedy_constraint_coloring_top.sv
// top level of the greedy constraint coloring block
//
//   channel   direction  handshake              payload
//   s_*       in         s_valid / s_ready      cmd, particle_a..d, member_count
//   m_*       out        m_valid / m_ready      assigned_color, colors_used, overflow
//   apb       in         psel, penable, pwrite  particle_limit at address 0
//
// a color request runs from acceptance to the next acceptance through four mask
// reads on the single read port, a gather and a pick step, four write-backs on
// the single write port (skipped on overflow), loading the result (held while the
// result register is full and not taken) and idle with s_ready high
// a clear request sweeps every mask entry, then reports
// reset starts the same sweep, with s_ready low
// the result register lets the next request enter while a result waits
module greedy_constraint_coloring_top #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_COLORS    = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcol_pkg::APB_AW-1:0]   paddr,
    input  logic [gcol_pkg::APB_DW-1:0]   pwdata,
    output logic [gcol_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [gcol_pkg::IDX_W-1:0]    s_particle_a,
    input  logic [gcol_pkg::IDX_W-1:0]    s_particle_b,
    input  logic [gcol_pkg::IDX_W-1:0]    s_particle_c,
    input  logic [gcol_pkg::IDX_W-1:0]    s_particle_d,
    input  logic [gcol_pkg::MCOUNT_W-1:0] s_member_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gcol_pkg::COLOR_W-1:0]  m_assigned_color,
    output logic [gcol_pkg::USED_W-1:0]   m_colors_used,
    output logic                          m_overflow
);
    import gcol_pkg::*;

    localparam int AW = $clog2(MAX_PARTICLES);

    logic [LIMIT_W-1:0]    particle_limit;
    particle_t             parts [FIELDS];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [MAX_COLORS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [MAX_COLORS-1:0] mem_rdata;

    assign parts[0] = s_particle_a;
    assign parts[1] = s_particle_b;
    assign parts[2] = s_particle_c;
    assign parts[3] = s_particle_d;

    gcol_apb u_apb (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .particle_limit (particle_limit)
    );

    gcol_mask_mem #(
        .DEPTH (MAX_PARTICLES),
        .WIDTH (MAX_COLORS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gcol_seq #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_COLORS    (MAX_COLORS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .particle_limit   (particle_limit),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_particle       (parts),
        .s_member_count   (s_member_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_assigned_color (m_assigned_color),
        .m_colors_used    (m_colors_used),
        .m_overflow       (m_overflow),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_re           (mem_re),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata)
    );

    // reset always starts the clearing sweep
    a_reset_sweep: assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("request accepted right after reset");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in flight");

    // overflow only when every color is in use
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_colors_used == USED_W'(MAX_COLORS)
            && m_assigned_color == '0)
        else $error("overflow reported with free colors left");

    // mask writes stay inside the store
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(MAX_PARTICLES)))
        else $error("mask write outside the store");

endmodule

// File: dv/greedy_constraint_coloring_top_tb.sv
// testbench for the greedy constraint coloring block: directed and random requests, checked
module greedy_constraint_coloring_top_tb;
    import gcol_pkg::*;

    localparam int MAX_PARTICLES = 1024;
    localparam int MAX_COLORS    = 32;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic                         cmd;
        logic [FIELDS-1:0][IDX_W-1:0] idx;
        logic [MCOUNT_W-1:0]          count;
        logic                         drain_first;
    } constraint_req_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [USED_W-1:0]  used;
        logic               overflow;
    } coloring_t;

    typedef enum {BURST_HUB, BURST_DENSE, BURST_NOISE, BURST_CLEAR} burst_kind_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_AW-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_cmd = CMD_COLOR;
    logic [IDX_W-1:0]      s_particle_a = '0;
    logic [IDX_W-1:0]      s_particle_b = '0;
    logic [IDX_W-1:0]      s_particle_c = '0;
    logic [IDX_W-1:0]      s_particle_d = '0;
    logic [MCOUNT_W-1:0]   s_member_count = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COLOR_W-1:0]    m_assigned_color;
    logic [USED_W-1:0]     m_colors_used;
    logic                  m_overflow;

    greedy_constraint_coloring_top #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .MAX_COLORS   (MAX_COLORS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_particle_a    (s_particle_a),
        .s_particle_b    (s_particle_b),
        .s_particle_c    (s_particle_c),
        .s_particle_d    (s_particle_d),
        .s_member_count  (s_member_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_assigned_color(m_assigned_color),
        .m_colors_used   (m_colors_used),
        .m_overflow      (m_overflow)
    );

    // predictor state
    logic [MAX_COLORS-1:0] color_masks [MAX_PARTICLES];
    int unsigned           colors_in_use = 0;
    logic [LIMIT_W-1:0]    limit_setting = LIMIT_RESET;

    constraint_req_t queued_constraints [$];
    coloring_t       pending_colorings [$];
    constraint_req_t next_req;
    constraint_req_t taken_req;
    coloring_t       want;
    int unsigned     mismatch_count = 0;
    int unsigned     send_idle = 0;
    int unsigned     sink_stall = 0;
    int unsigned     quiet_left = 0;
    logic            req_accepted = 1'b0;

    initial begin
        foreach (color_masks[i]) color_masks[i] = '0;
    end

    initial forever #1 aclk = ~aclk;

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit tracked(input particle_t p);
        return p < limit_setting && p < MAX_PARTICLES;
    endfunction

    function automatic coloring_t color_constraint(input constraint_req_t r);
        coloring_t             res;
        logic [MAX_COLORS-1:0] taken;
        int unsigned           n;
        int unsigned           pick;
        bit                    free_found;
        res = '0;
        taken = '0;
        pick = 0;
        free_found = 1'b0;
        if (r.cmd == CMD_CLEAR) begin
            foreach (color_masks[i]) color_masks[i] = '0;
            colors_in_use = 0;
            return res;
        end
        n = (r.count > FIELDS_USED) ? FIELDS_USED : r.count;
        for (int k = 0; k < n; k++)
            if (tracked(r.idx[k])) taken |= color_masks[r.idx[k]];
        // walk down so the lowest free color wins
        for (int c = MAX_COLORS - 1; c >= 0; c--) begin
            if (!taken[c]) begin
                pick = c;
                free_found = 1'b1;
            end
        end
        if (!free_found) begin
            res.used = USED_W'(colors_in_use);
            res.overflow = 1'b1;
            return res;
        end
        for (int k = 0; k < n; k++)
            if (tracked(r.idx[k])) color_masks[r.idx[k]][pick] = 1'b1;
        if (pick + 1 > colors_in_use) colors_in_use = pick + 1;
        res.color = COLOR_W'(pick);
        res.used = USED_W'(colors_in_use);
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int exp_val);
        if (mismatch_count < 100)
            $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_val, $realtime);
        mismatch_count++;
    endtask

    // mostly no gap, some short, a few long, with occasional stretches of no gap at all
    function automatic int unsigned gap_length();
        int unsigned roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_request(input logic cmd, input int unsigned n,
                                        input particle_t a, input particle_t b,
                                        input particle_t c, input particle_t d,
                                        input logic drain);
        constraint_req_t r;
        r.cmd = cmd;
        r.idx = {d, c, b, a};
        r.count = MCOUNT_W'(n);
        r.drain_first = drain;
        queued_constraints = {queued_constraints, r};
    endfunction

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_accepted) begin
            if (send_idle > 0) begin
                send_idle--;
                s_valid <= 1'b0;
            end else if (queued_constraints.size() > 0 &&
                         !(queued_constraints[0].drain_first && pending_colorings.size() > 0)) begin
                next_req = queued_constraints.pop_front();
                s_cmd <= next_req.cmd;
                s_particle_a <= next_req.idx[0];
                s_particle_b <= next_req.idx[1];
                s_particle_c <= next_req.idx[2];
                s_particle_d <= next_req.idx[3];
                s_member_count <= next_req.count;
                s_valid <= 1'b1;
                send_idle = gap_length();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_stall = gap_length();
        end
    end

    // monitor: check results first so a same-edge request never matches itself
    always @(posedge aclk) begin
        req_accepted <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_colorings.size() == 0) begin
                    flag_mismatch("result with no request pending", m_assigned_color, 0);
                end else begin
                    want = pending_colorings.pop_front();
                    if (m_assigned_color !== want.color)
                        flag_mismatch("assigned_color", m_assigned_color, want.color);
                    if (m_colors_used !== want.used)
                        flag_mismatch("colors_used", m_colors_used, want.used);
                    if (m_overflow !== want.overflow)
                        flag_mismatch("overflow", m_overflow, want.overflow);
                end
            end
            if (s_valid && s_ready) begin
                taken_req.cmd = s_cmd;
                taken_req.idx = {s_particle_d, s_particle_c, s_particle_b, s_particle_a};
                taken_req.count = s_member_count;
                taken_req.drain_first = 1'b0;
                pending_colorings = {pending_colorings, color_constraint(taken_req)};
            end
        end
    end

    task automatic write_particle_limit(input logic [LIMIT_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PARTICLE_LIMIT, 2'b00};
        pwdata <= APB_DW'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        limit_setting = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle();
        while (queued_constraints.size() != 0 || s_valid || pending_colorings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_phase(input int unsigned target);
        int unsigned made;
        int unsigned span;
        int unsigned base;
        int unsigned psize;
        int unsigned len;
        int unsigned hub;
        int unsigned n;
        int unsigned roll;
        particle_t   p [FIELDS];
        burst_kind_t kind;
        made = 0;
        span = (limit_setting == 0 || limit_setting > MAX_PARTICLES) ?
               MAX_PARTICLES : limit_setting;
        while (made < target) begin
            roll = $urandom_range(0, 99);
            kind = roll < 25 ? BURST_HUB : roll < 70 ? BURST_DENSE :
                   roll < 88 ? BURST_NOISE : BURST_CLEAR;
            base = $urandom_range(0, span - 1);
            psize = $urandom_range(4, 32);
            case (kind)
                BURST_HUB: begin
                    // one particle in every request, so its mask fills up and overflows
                    hub = base;
                    len = $urandom_range(33, 45);
                    for (int i = 0; i < len; i++) begin
                        n = $urandom_range(1, FIELDS);
                        for (int k = 0; k < FIELDS; k++)
                            p[k] = particle_t'((hub + $urandom_range(1, psize)) % span);
                        p[$urandom_range(0, n - 1)] = particle_t'(hub);
                        add_request(CMD_COLOR, n, p[0], p[1], p[2], p[3], 1'b0);
                    end
                    made += len;
                end
                BURST_DENSE: begin
                    len = $urandom_range(20, 60);
                    for (int i = 0; i < len; i++) begin
                        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) :
                                                          $urandom_range(2, FIELDS);
                        for (int k = 0; k < FIELDS; k++)
                            p[k] = ($urandom_range(0, 19) == 0) ? particle_t'($urandom) :
                                   particle_t'((base + $urandom_range(0, psize - 1)) % span);
                        add_request(CMD_COLOR, n, p[0], p[1], p[2], p[3], 1'b0);
                    end
                    made += len;
                end
                BURST_NOISE: begin
                    len = $urandom_range(4, 12);
                    for (int i = 0; i < len; i++)
                        add_request(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_COLOR,
                                    $urandom_range(0, 7), particle_t'($urandom),
                                    particle_t'($urandom), particle_t'($urandom),
                                    particle_t'($urandom), 1'b0);
                    made += len;
                end
                default: begin
                    add_request(CMD_CLEAR, $urandom_range(0, 7), particle_t'($urandom),
                                particle_t'($urandom), particle_t'($urandom),
                                particle_t'($urandom), logic'($urandom_range(0, 1)));
                    made++;
                end
            endcase
        end
    endtask

    initial begin
        // directed requests at the reset limit
        add_request(CMD_CLEAR, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 0, 16'hFFFF, 16'h0001, 16'h03FF, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 4, 16'h0000, 16'h0001, 16'h0002, 16'h0003, 1'b0);
        add_request(CMD_COLOR, 4, 16'h03FF, 16'h0400, 16'hFFFF, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 7, 16'h0000, 16'h0005, 16'h0006, 16'h0007, 1'b0);
        add_request(CMD_COLOR, 5, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 6, 16'h0006, 16'h0007, 16'h0005, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 2, 16'h03FF, 16'h03FF, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 3, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 1'b0);
        add_request(CMD_COLOR, 3, 16'h02AA, 16'h0155, 16'h03FF, 16'h0000, 1'b0);
        add_request(CMD_CLEAR, 4, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b1);
        add_request(CMD_COLOR, 4, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 1'b0);
        add_request(CMD_COLOR, 1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_COLOR, 2, 16'h0001, 16'h0002, 16'h0000, 16'h0000, 1'b0);
        add_request(CMD_CLEAR, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_request(CMD_COLOR, 4, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 1'b0);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        queue_phase(110);
        settle();
        write_particle_limit('0);
        queue_phase(50);
        settle();
        write_particle_limit(LIMIT_W'(1));
        queue_phase(50);
        settle();
        write_particle_limit(LIMIT_W'($urandom_range(2, 1023)));
        queue_phase(120);
        settle();
        write_particle_limit(LIMIT_RESET);
        queue_phase(110);
        settle();
        write_particle_limit(LIMIT_W'($urandom_range(1, 1023)));
        queue_phase(110);
        settle();

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
